// ===== hw/rtl/input_log_run_length_encoder_top_macros.svh =====
// ============================================================================
// Assertion macros for the input log run length encoder
// Shared checks, clocked on clk and held off while rst_n is low.
// ============================================================================
`ifndef INPUT_LOG_RUN_LENGTH_ENCODER_TOP_MACROS_SVH
`define INPUT_LOG_RUN_LENGTH_ENCODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ILRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ILRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ilre_pkg.sv =====
// ============================================================================
// ilre_pkg
// Types, codes, constants and the CRC-32C byte step shared by the encoder.
// ============================================================================
package ilre_pkg;

    // sizes
    localparam int unsigned LIT_MAX       = 9;   // literal bytes in one job
    localparam int unsigned MAX_BYTES     = 13;  // bytes one item can cause
    localparam int unsigned JOB_DEPTH_DEF = 2;   // front-to-back queue depth
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 8;
    localparam int unsigned BCNT_W        = 4;   // byte count / byte index

    // commands
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_FRAME  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYS_FLAG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD1_FLAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD2_FLAG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_SHORT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LONG  = 3'd4;

    // register reset values
    localparam logic [6:0] SYS_FLAG_RST  = 7'd1;
    localparam logic [6:0] PAD1_FLAG_RST = 7'd2;
    localparam logic [6:0] PAD2_FLAG_RST = 7'd4;
    localparam logic [7:0] REP_SHORT_RST = 8'd254;
    localparam logic [7:0] REP_LONG_RST  = 8'd255;

    // stream constants
    localparam logic [31:0] CRC_POLY      = 32'h82F63B78;
    localparam logic [31:0] SHORT_RUN_MAX = 32'h0000007E;
    localparam logic [31:0] MID_RUN_MAX   = 32'h0000FFFF;
    localparam logic [31:0] RUN_LIMIT     = 32'hFFFFFFFF;
    localparam logic [7:0]  RUN_TAG       = 8'h80;
    localparam logic [7:0]  HDR_BYTE0     = 8'h4E;  // 'N'
    localparam logic [7:0]  HDR_BYTE1     = 8'h54;  // 'T'
    localparam logic [7:0]  HDR_BYTE2     = 8'h01;
    localparam logic [7:0]  HDR_BYTE3     = 8'h00;

    // one item's work as handed from front to back
    typedef struct packed {
        logic [LIT_MAX-1:0][7:0] lit;       // byte 0 goes out first
        logic [BCNT_W-1:0]       nlit;      // literal byte count
        logic                    crc_tail;  // append the running CRC, big-endian
        logic                    crc_clr;   // CRC restarts from zero at byte 0
    } job_t;

    typedef struct packed {
        logic frame_zero;
        logic run_zero;
    } front_stat_t;

    typedef struct packed {
        logic              busy;
        logic [BCNT_W-1:0] byte_idx;
    } back_stat_t;

    // reflected CRC-32C, one byte
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/ilre_front.sv =====
// ============================================================================
// ilre_front
// Takes items, tracks frame and run state and builds each item's byte job.
// ============================================================================
module ilre_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ilre_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ilre_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               take,
    input  logic [1:0]                         cmd,
    input  logic [7:0]                         system_code,
    input  logic [7:0]                         pad1_buttons,
    input  logic [7:0]                         pad2_buttons,
    output logic                               job_push,
    output ilre_pkg::job_t                     job,
    output ilre_pkg::front_stat_t              stat
);
    import ilre_pkg::*;

    logic [6:0]  sys_flag_reg, pad1_flag_reg, pad2_flag_reg;
    logic [7:0]  rep_short_reg, rep_long_reg;
    logic [31:0] frame_cnt_reg, frame_cnt_next;
    logic [31:0] run_cnt_reg, run_cnt_next;
    logic [7:0]  prev_sys_reg, prev_sys_next;
    logic [7:0]  prev_pad1_reg, prev_pad1_next;
    logic [7:0]  prev_pad2_reg, prev_pad2_next;

    logic        same;
    logic        run_full;
    logic [31:0] run_m1;
    logic [31:0] fcnt_m1;
    logic [4:0][7:0] fl_raw;
    logic [2:0]  fl_raw_len;
    logic [4:0][7:0] fl;
    logic [2:0]  fl_len;
    logic        use_flush;
    logic [3:0][7:0] body;
    logic [2:0]  blen;
    logic [6:0]  flags;
    logic        has_job;
    logic        tail_req;
    logic        clr_req;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sys_flag_reg  <= SYS_FLAG_RST;
            pad1_flag_reg <= PAD1_FLAG_RST;
            pad2_flag_reg <= PAD2_FLAG_RST;
            rep_short_reg <= REP_SHORT_RST;
            rep_long_reg  <= REP_LONG_RST;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_SYS_FLAG:  sys_flag_reg  <= cfg_data[6:0];
                REG_PAD1_FLAG: pad1_flag_reg <= cfg_data[6:0];
                REG_PAD2_FLAG: pad2_flag_reg <= cfg_data[6:0];
                REG_REP_SHORT: rep_short_reg <= cfg_data;
                REG_REP_LONG:  rep_long_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // classification
    assign same = (frame_cnt_reg != '0) && (system_code == prev_sys_reg)
                  && (pad1_buttons == prev_pad1_reg) && (pad2_buttons == prev_pad2_reg);
    assign run_full = (run_cnt_reg == RUN_LIMIT);
    assign run_m1   = run_cnt_reg - 32'd1;
    assign fcnt_m1  = frame_cnt_reg - 32'd1;

    // pending run as a repeat entry
    always_comb begin
        fl_raw     = '0;
        fl_raw_len = 3'd0;
        if (run_cnt_reg == '0) begin
            fl_raw_len = 3'd0;
        end
        else if (run_cnt_reg <= SHORT_RUN_MAX) begin
            fl_raw[0]  = RUN_TAG | {1'b0, run_m1[6:0]};
            fl_raw_len = 3'd1;
        end
        else if (run_cnt_reg <= MID_RUN_MAX) begin
            fl_raw[0]  = rep_short_reg;
            fl_raw[1]  = run_cnt_reg[15:8];
            fl_raw[2]  = run_cnt_reg[7:0];
            fl_raw_len = 3'd3;
        end
        else begin
            fl_raw[0]  = rep_long_reg;
            fl_raw[1]  = run_cnt_reg[31:24];
            fl_raw[2]  = run_cnt_reg[23:16];
            fl_raw[3]  = run_cnt_reg[15:8];
            fl_raw[4]  = run_cnt_reg[7:0];
            fl_raw_len = 3'd5;
        end
    end

    // job body and next state per command
    always_comb begin
        use_flush      = 1'b0;
        body           = '0;
        blen           = 3'd0;
        flags          = '0;
        has_job        = 1'b0;
        tail_req       = 1'b0;
        clr_req        = 1'b0;
        frame_cnt_next = frame_cnt_reg;
        run_cnt_next   = run_cnt_reg;
        prev_sys_next  = prev_sys_reg;
        prev_pad1_next = prev_pad1_reg;
        prev_pad2_next = prev_pad2_reg;
        case (cmd)
            CMD_START: begin
                body[0]        = HDR_BYTE0;
                body[1]        = HDR_BYTE1;
                body[2]        = HDR_BYTE2;
                body[3]        = HDR_BYTE3;
                blen           = 3'd4;
                has_job        = 1'b1;
                clr_req        = 1'b1;
                frame_cnt_next = '0;
                run_cnt_next   = '0;
                prev_sys_next  = '0;
                prev_pad1_next = '0;
                prev_pad2_next = '0;
            end
            CMD_FRAME: begin
                frame_cnt_next = frame_cnt_reg + 32'd1;
                if (same) begin
                    // repeat: only a saturated run produces bytes
                    use_flush    = run_full;
                    has_job      = run_full;
                    run_cnt_next = run_full ? 32'd1 : (run_cnt_reg + 32'd1);
                end
                else begin
                    use_flush      = 1'b1;
                    has_job        = 1'b1;
                    run_cnt_next   = '0;
                    prev_sys_next  = system_code;
                    prev_pad1_next = pad1_buttons;
                    prev_pad2_next = pad2_buttons;
                    if (system_code != '0) flags = flags | sys_flag_reg;
                    if (pad1_buttons != '0) flags = flags | pad1_flag_reg;
                    if (pad2_buttons != '0) flags = flags | pad2_flag_reg;
                    body[0] = {1'b0, flags};
                    blen    = 3'd1;
                    if (system_code != '0) begin
                        body[blen[1:0]] = system_code;
                        blen            = blen + 3'd1;
                    end
                    if (pad1_buttons != '0) begin
                        body[blen[1:0]] = pad1_buttons;
                        blen            = blen + 3'd1;
                    end
                    if (pad2_buttons != '0) begin
                        body[blen[1:0]] = pad2_buttons;
                        blen            = blen + 3'd1;
                    end
                end
            end
            CMD_FINISH: begin
                use_flush    = 1'b1;
                has_job      = 1'b1;
                tail_req     = 1'b1;
                run_cnt_next = '0;
                body[0]      = fcnt_m1[31:24];
                body[1]      = fcnt_m1[23:16];
                body[2]      = fcnt_m1[15:8];
                body[3]      = fcnt_m1[7:0];
                blen         = 3'd4;
            end
            default: ;
        endcase
    end

    // flush bytes first, body behind them
    assign fl           = use_flush ? fl_raw : '0;
    assign fl_len       = use_flush ? fl_raw_len : 3'd0;
    assign job.lit      = ({40'h0, body} << {fl_len, 3'b000}) | {32'h0, fl};
    assign job.nlit     = {1'b0, fl_len} + {1'b0, blen};
    assign job.crc_tail = tail_req;
    assign job.crc_clr  = clr_req;
    assign job_push     = take && has_job;

    // frame and run state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_cnt_reg <= '0;
            run_cnt_reg   <= '0;
            prev_sys_reg  <= '0;
            prev_pad1_reg <= '0;
            prev_pad2_reg <= '0;
        end
        else if (take) begin
            frame_cnt_reg <= frame_cnt_next;
            run_cnt_reg   <= run_cnt_next;
            prev_sys_reg  <= prev_sys_next;
            prev_pad1_reg <= prev_pad1_next;
            prev_pad2_reg <= prev_pad2_next;
        end
    end

    assign stat.frame_zero = (frame_cnt_reg == '0);
    assign stat.run_zero   = (run_cnt_reg == '0);

endmodule

// ===== hw/rtl/ilre_jobq.sv =====
// ============================================================================
// ilre_jobq
// Small register queue of byte jobs between the front and the back.
// ============================================================================
module ilre_jobq #(
    parameter int unsigned DEPTH = ilre_pkg::JOB_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  ilre_pkg::job_t wr_job,
    input  logic           rd,
    output ilre_pkg::job_t rd_job,
    output logic           full,
    output logic           empty
);
    import ilre_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_job = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
        end
    end

endmodule

// ===== hw/rtl/ilre_back.sv =====
// ============================================================================
// ilre_back: serializes jobs, runs the CRC and holds a result queue.
// One byte a cycle, stalling while the result queue is full or no job waits.
// ============================================================================
module ilre_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ilre_pkg::job_t       job,
    input  logic                 job_empty,
    output logic                 job_pop,
    input  logic                 pop,
    output logic                 empty,
    output logic [7:0]           out_byte,
    output logic                 last_of_run,
    output ilre_pkg::back_stat_t stat
);
    import ilre_pkg::*;

    logic [BCNT_W-1:0] idx_reg, idx_next;
    logic [31:0]       crc_reg, crc_next;
    logic [31:0]       sh_reg, sh_next;
    logic [BCNT_W-1:0] total;
    logic              go, at_last;
    logic [7:0]        cur_byte;
    logic [31:0]       crc_base;

    logic [7:0]        ob_byte_reg [2];
    logic              ob_last_reg [2];
    logic              ob_wr_reg, ob_rd_reg;
    logic [1:0]        ob_cnt_reg;
    logic              ob_pop;

    // byte sequencing
    assign total   = job.nlit + (job.crc_tail ? BCNT_W'(4) : BCNT_W'(0));
    assign go      = !job_empty && (ob_cnt_reg != 2'd2);
    assign at_last = (idx_reg == total - BCNT_W'(1));
    assign job_pop = go && at_last;

    // byte select: literals, then CRC captured at the first tail byte
    always_comb begin
        if (idx_reg < job.nlit) begin
            cur_byte = job.lit[idx_reg];
        end
        else if (idx_reg == job.nlit) begin
            cur_byte = crc_reg[31:24];
        end
        else begin
            cur_byte = sh_reg[31:24];
        end
    end

    assign crc_base = ((idx_reg == '0) && job.crc_clr) ? '0 : crc_reg;
    assign crc_next = crc32c_byte(crc_base, cur_byte);
    assign sh_next  = (idx_reg == job.nlit) ? {crc_reg[23:0], 8'h00} : {sh_reg[23:0], 8'h00};
    assign idx_next = at_last ? '0 : idx_reg + BCNT_W'(1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg <= '0;
            crc_reg <= '0;
        end
        else if (go) begin
            idx_reg <= idx_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk) begin
        if (go) begin
            sh_reg <= sh_next;
        end
    end

    // two-entry result queue
    assign ob_pop = pop && (ob_cnt_reg != 2'd0);

    always_ff @(posedge clk) begin
        if (go) begin
            ob_byte_reg[ob_wr_reg] <= cur_byte;
            ob_last_reg[ob_wr_reg] <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else begin
            if (go) ob_wr_reg <= ~ob_wr_reg;
            if (ob_pop) ob_rd_reg <= ~ob_rd_reg;
            ob_cnt_reg <= ob_cnt_reg + {1'b0, go} - {1'b0, ob_pop};
        end
    end

    assign empty       = (ob_cnt_reg == 2'd0);
    assign out_byte    = ob_byte_reg[ob_rd_reg];
    assign last_of_run = ob_last_reg[ob_rd_reg];

    assign stat.busy     = !job_empty;
    assign stat.byte_idx = idx_reg;

endmodule

// ===== hw/rtl/input_log_run_length_encoder_top.sv =====
// Path: an item's first byte is written to the job queue, then to the result queue, and is
// then on the result ports. Throughput: one result byte per cycle while the result queue
// has room; an item yields 0 to 13 bytes and holds the byte serializer until its last
// byte, one CRC-32C step per byte. Items with no bytes queue no job. The job queue holds
// JOB_DEPTH jobs, the one being serialized included. Reset: asynchronous, clears frame, run,
// CRC and queue state and loads register defaults.
// ============================================================================
// input_log_run_length_encoder_top
// Input log encoder with run-length repeats and a CRC-32C trailer.
// ============================================================================
module input_log_run_length_encoder_top #(
    parameter int unsigned JOB_DEPTH = ilre_pkg::JOB_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ilre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ilre_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      cmd,
    input  logic [7:0]                      system_code,
    input  logic [7:0]                      pad1_buttons,
    input  logic [7:0]                      pad2_buttons,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      out_byte,
    output logic                            last_of_run
);
    import ilre_pkg::*;

    logic        take;
    logic        jq_push, jq_pop, jq_full, jq_empty;
    job_t        front_job, head_job;
    front_stat_t fstat;
    back_stat_t  bstat;

    // input transfer
    assign full = jq_full;
    assign take = push && !jq_full;

    ilre_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .cmd          (cmd),
        .system_code  (system_code),
        .pad1_buttons (pad1_buttons),
        .pad2_buttons (pad2_buttons),
        .job_push     (jq_push),
        .job          (front_job),
        .stat         (fstat)
    );

    ilre_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (jq_push),
        .wr_job (front_job),
        .rd     (jq_pop),
        .rd_job (head_job),
        .full   (jq_full),
        .empty  (jq_empty)
    );

    ilre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (head_job),
        .job_empty   (jq_empty),
        .job_pop     (jq_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .stat        (bstat)
    );

    // checks
    `include "input_log_run_length_encoder_top_macros.svh"

    `ILRE_ASSERT_NEXT(a_start_clears, take && (cmd == CMD_START), fstat.frame_zero && fstat.run_zero, "start did not clear frame and run state")
    `ILRE_ASSERT_NOW(a_idx_bound, 1'b1, bstat.byte_idx <= BCNT_W'(MAX_BYTES - 1), "byte index past the longest job")
    `ILRE_ASSERT_NOW(a_idx_needs_job, bstat.byte_idx != '0, bstat.busy, "byte index advanced with no job queued")

endmodule
